// File: hdl/gco_pkg.sv
// Package for the grid cell occlusion test: coordinate width, packed input
// layout, stage payload types and small sign helpers.
// No dependencies; every other file in hdl/ imports it.
package gco_pkg;

    // Width of one grid coordinate.
    localparam int COORD_BITS = 10;
    localparam int NUM_FIELDS = 6;
    localparam int IN_BITS    = NUM_FIELDS * COORD_BITS;
    localparam int TDATA_W    = ((IN_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W  = 8;

    // Signed width for coordinate differences and the doubled offsets.
    localparam int CW = COORD_BITS + 2;
    // Width of one product and of the summed cross products.
    localparam int PW = 2 * CW;
    localparam int SW = 2 * CW + 2;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic signed [CW-1:0]  cval_t;
    typedef logic signed [PW-1:0]  prod_t;
    typedef logic signed [SW-1:0]  sum_t;

    // Input fields; the last member lands in the lowest bits.
    typedef struct packed {
        coord_t dest_y;
        coord_t dest_x;
        coord_t obstacle_y;
        coord_t obstacle_x;
        coord_t source_y;
        coord_t source_x;
    } coords_t;

    // After the first stage: segment direction, obstacle offsets and the
    // per-diagonal flags (diagonal not parallel and straddled by the segment).
    typedef struct packed {
        cval_t ex;
        cval_t ey;
        cval_t fx;
        cval_t fy;
        logic  en1;
        logic  en2;
    } prep_t;

    typedef struct packed {
        prod_t m1;
        prod_t m2;
        cval_t ex;
        cval_t ey;
        logic  en1;
        logic  en2;
    } mul_t;

    typedef struct packed {
        sum_t  v3;
        cval_t ex;
        cval_t ey;
        logic  en1;
        logic  en2;
    } cross_t;

    function automatic cval_t ext_coord(input coord_t v);
        return $signed({2'b00, v});
    endfunction

    // True when the two signs are not equal and nonzero, i.e. their product
    // is zero or negative.
    function automatic logic straddles(input logic a_pos, input logic a_neg,
                                       input logic b_pos, input logic b_neg);
        return !((a_pos && b_pos) || (a_neg && b_neg));
    endfunction

endpackage

// File: hdl/gco_prep.sv
// First pipeline stage: doubled-coordinate differences and the obstacle-side
// orientation tests, which reduce to narrow adds.
// Depends on gco_pkg.
module gco_prep
    import gco_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  coords_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output prep_t   out_data
);

    logic  valid_reg;
    prep_t data_reg;
    prep_t data_next;

    cval_t sx, sy, ox, oy, dx, dy;
    cval_t a1s, a1d, a2s, a2d;
    logic  side1, side2, par1, par2;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        sx = ext_coord(in_data.source_x);
        sy = ext_coord(in_data.source_y);
        ox = ext_coord(in_data.obstacle_x);
        oy = ext_coord(in_data.obstacle_y);
        dx = ext_coord(in_data.dest_x);
        dy = ext_coord(in_data.dest_y);

        data_next.ex = dx - sx;
        data_next.ey = dy - sy;
        // Obstacle corner minus source centre, in doubled units.
        data_next.fx = ((ox - sx) <<< 1) - cval_t'(1);
        data_next.fy = ((oy - sy) <<< 1) - cval_t'(1);

        // Which side of each diagonal the two centres lie on.
        a1s = (sy - sx) - (oy - ox);
        a1d = (dy - dx) - (oy - ox);
        a2s = (ox + oy) - (sx + sy);
        a2d = (ox + oy) - (dx + dy);
        side1 = straddles(!a1s[CW-1] && (a1s != '0), a1s[CW-1],
                          !a1d[CW-1] && (a1d != '0), a1d[CW-1]);
        side2 = straddles(!a2s[CW-1] && (a2s != '0), a2s[CW-1],
                          !a2d[CW-1] && (a2d != '0), a2d[CW-1]);

        // A segment parallel to a diagonal never counts; this also covers
        // the zero-length segment.
        par1 = (data_next.ex == data_next.ey);
        par2 = ((data_next.ex + data_next.ey) == '0);
        data_next.en1 = side1 && !par1;
        data_next.en2 = side2 && !par2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: hdl/gco_mul.sv
// Second pipeline stage: the two products of the segment-side cross product.
// Depends on gco_pkg.
module gco_mul
    import gco_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  prep_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output mul_t  out_data
);

    logic valid_reg;
    mul_t data_reg;
    mul_t data_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        data_next.m1  = prod_t'(in_data.ex) * prod_t'(in_data.fy);
        data_next.m2  = prod_t'(in_data.ey) * prod_t'(in_data.fx);
        data_next.ex  = in_data.ex;
        data_next.ey  = in_data.ey;
        data_next.en1 = in_data.en1;
        data_next.en2 = in_data.en2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: hdl/gco_eval.sv
// Third and fourth pipeline stages: the cross product at the first corner,
// then the shifted values at the other three corners, their signs and the
// result register.
// Depends on gco_pkg.
module gco_eval
    import gco_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  mul_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output logic out_blocked
);

    logic   cross_valid_reg;
    cross_t cross_reg;
    cross_t cross_next;
    logic   cross_ready;

    logic   res_valid_reg;
    logic   blocked_reg;
    logic   blocked_next;

    sum_t   wb1, wa2, wb2;
    logic   hit1, hit2;

    assign cross_ready = !res_valid_reg || out_ready;
    assign in_ready    = !cross_valid_reg || cross_ready;

    always_comb begin
        cross_next.v3  = sum_t'(in_data.m1) - sum_t'(in_data.m2);
        cross_next.ex  = in_data.ex;
        cross_next.ey  = in_data.ey;
        cross_next.en1 = in_data.en1;
        cross_next.en2 = in_data.en2;
    end

    // Moving the corner by two doubled units changes the cross product by
    // a multiple of the direction, so each other corner is one add away.
    always_comb begin
        wb1 = cross_reg.v3 + ((sum_t'(cross_reg.ex) - sum_t'(cross_reg.ey)) <<< 1);
        wa2 = cross_reg.v3 - (sum_t'(cross_reg.ey) <<< 1);
        wb2 = cross_reg.v3 + (sum_t'(cross_reg.ex) <<< 1);
        hit1 = cross_reg.en1 &&
               straddles(!cross_reg.v3[SW-1] && (cross_reg.v3 != '0), cross_reg.v3[SW-1],
                         !wb1[SW-1] && (wb1 != '0), wb1[SW-1]);
        hit2 = cross_reg.en2 &&
               straddles(!wa2[SW-1] && (wa2 != '0), wa2[SW-1],
                         !wb2[SW-1] && (wb2 != '0), wb2[SW-1]);
        blocked_next = hit1 || hit2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cross_valid_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end else begin
            if (in_ready) begin
                cross_valid_reg <= in_valid;
            end
            if (cross_ready) begin
                res_valid_reg <= cross_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            cross_reg <= cross_next;
        end
        if (cross_valid_reg && cross_ready) begin
            blocked_reg <= blocked_next;
        end
    end

    assign out_valid   = res_valid_reg;
    assign out_blocked = blocked_reg;

endmodule

// File: hdl/grid_cell_occlusion_test.sv
// Top level of the grid cell occlusion test: stream ports, field unpacking
// and the four-stage pipeline.
// Depends on gco_pkg, gco_prep, gco_mul and gco_eval.

// Each transfer names a source, an obstacle and a destination cell; the result
// says whether the segment between the source and destination centres meets
// either diagonal of the obstacle's unit square, touching included and
// parallel diagonals excluded. The arithmetic is exact on doubled integer
// coordinates. The pipeline has four register stages (differences and
// obstacle-side signs, two products, the cross product, corner signs into the
// result register), and one query is taken every cycle while m_tready stays
// high; with m_tready low the pipeline fills its empty stages and then holds.
module grid_cell_occlusion_test
    import gco_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // source_x, source_y, obstacle_x, obstacle_y, dest_x, dest_y, zero fill
    input  logic [TDATA_W-1:0]   s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // blocked, zero fill
    output logic [M_TDATA_W-1:0] m_tdata
);

    coords_t coords;
    logic    p_valid, p_ready;
    prep_t   p_data;
    logic    q_valid, q_ready;
    mul_t    q_data;
    logic    blocked;

    assign coords = coords_t'(s_tdata[IN_BITS-1:0]);

    gco_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (coords),
        .out_valid (p_valid),
        .out_ready (p_ready),
        .out_data  (p_data)
    );

    gco_mul u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (p_valid),
        .in_ready  (p_ready),
        .in_data   (p_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    gco_eval u_eval (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (q_valid),
        .in_ready    (q_ready),
        .in_data     (q_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_blocked (blocked)
    );

    assign m_tdata = {{(M_TDATA_W-1){1'b0}}, blocked};

    // The input side only stalls when every stage is full behind a stalled
    // output.
    a_full_only_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready && p_valid && q_valid))
        else $error("input stalled while the pipeline had room");

    a_reset_empties: assert property (@(posedge aclk)
        $past(!aresetn) |-> (!m_tvalid && !p_valid && !q_valid))
        else $error("pipeline not empty after reset");

    a_prep_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (p_valid && !p_ready) |=> (p_valid && $stable(p_data)))
        else $error("first stage lost or changed a stalled item");

endmodule

// File: tb/gco_checker.sv
// Checker for the grid cell occlusion test: watches both stream channels,
// predicts each verdict from the accepted query and compares in order.
// Depends on gco_pkg for the coordinate types and the tdata widths.
module gco_checker
    import gco_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [TDATA_W-1:0]   s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   mismatches,
    output int                   outstanding,
    output int                   verdicts_checked,
    output int                   blocked_seen
);

    typedef struct {
        coords_t query;
        bit      blocked;
    } verdict_t;

    verdict_t expected_verdicts[$];

    function automatic int sign_of(input longint v);
        if (v > 0) begin
            return 1;
        end else if (v < 0) begin
            return -1;
        end
        return 0;
    endfunction

    // Sign of the cross product (b - a) x (c - a).
    function automatic int turn(input longint ax, ay, bx, by, cx, cy);
        return sign_of((bx - ax) * (cy - ay) - (by - ay) * (cx - ax));
    endfunction

    // Segment p-q against diagonal a-b. Touching counts; a parallel diagonal,
    // collinear overlap included, never does.
    function automatic bit meets_diagonal(input longint px, py, qx, qy,
                                          input longint ax, ay, bx, by);
        longint cr;
        cr = (qx - px) * (by - ay) - (qy - py) * (bx - ax);
        if (cr == 0) begin
            return 1'b0;
        end
        return (turn(ax, ay, bx, by, px, py) * turn(ax, ay, bx, by, qx, qy) <= 0) &&
               (turn(px, py, qx, qy, ax, ay) * turn(px, py, qx, qy, bx, by) <= 0);
    endfunction

    // Doubled coordinates: a cell centre sits at 2x+1, the square's corners
    // at 2x and 2x+2, so everything stays in exact integers.
    function automatic bit predict_blocked(input coords_t q);
        longint px, py, qx, qy, lx, ty, rx, by;
        px = 2 * longint'(q.source_x) + 1;
        py = 2 * longint'(q.source_y) + 1;
        qx = 2 * longint'(q.dest_x) + 1;
        qy = 2 * longint'(q.dest_y) + 1;
        lx = 2 * longint'(q.obstacle_x);
        ty = 2 * longint'(q.obstacle_y);
        rx = lx + 2;
        by = ty + 2;
        if (px == qx && py == qy) begin
            return 1'b0;
        end
        return meets_diagonal(px, py, qx, qy, lx, ty, rx, by) ||
               meets_diagonal(px, py, qx, qy, rx, ty, lx, by);
    endfunction

    always @(posedge aclk) begin : watch
        verdict_t want;
        coords_t  q;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                q            = s_tdata[IN_BITS-1:0];
                want.query   = q;
                want.blocked = predict_blocked(q);
                expected_verdicts.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                if (expected_verdicts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result transfer with no query waiting: m_tdata %h", m_tdata);
                    end
                end else begin
                    want = expected_verdicts.pop_front();
                    verdicts_checked++;
                    if (m_tdata[0] === 1'b1) begin
                        blocked_seen++;
                    end
                    if (m_tdata[0] !== want.blocked) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("src (%0d,%0d) obstacle (%0d,%0d) dst (%0d,%0d): %s %0b, %s %0b",
                                     want.query.source_x, want.query.source_y,
                                     want.query.obstacle_x, want.query.obstacle_y,
                                     want.query.dest_x, want.query.dest_y,
                                     "blocked expected", want.blocked, "got", m_tdata[0]);
                        end
                    end
                end
            end
        end
        outstanding = expected_verdicts.size();
    end

endmodule

// File: tb/tb.sv
// Top of the grid cell occlusion test bench: clock, reset, query stimulus,
// result back-pressure and the final verdict.
// Depends on gco_pkg, grid_cell_occlusion_test and gco_checker.
module tb;
    import gco_pkg::*;

    localparam int COORD_MAX = (1 << COORD_BITS) - 1;
    localparam int RANDOM_QUERIES = 1330;
    localparam int LONG_HOLD = 300;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    int mismatches;
    int outstanding;
    int verdicts_checked;
    int blocked_seen;

    // Shared between the two driving processes: no random gaps while steady is
    // set, and a pending request for a long output stall, honoured even then.
    bit steady;
    int hold_requests;

    always #10 aclk = ~aclk;

    grid_cell_occlusion_test u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    gco_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .mismatches       (mismatches),
        .outstanding      (outstanding),
        .verdicts_checked (verdicts_checked),
        .blocked_seen     (blocked_seen)
    );

    function automatic int clamp_coord(input int v);
        if (v < 0) begin
            return 0;
        end else if (v > COORD_MAX) begin
            return COORD_MAX;
        end
        return v;
    endfunction

    // Entered and left at a falling edge; returns once the query transfer
    // has taken place.
    task automatic offer_query(input int sx, sy, ox, oy, dx, dy);
        coords_t q;
        int      gap;
        q.source_x   = coord_t'(sx);
        q.source_y   = coord_t'(sy);
        q.obstacle_x = coord_t'(ox);
        q.obstacle_y = coord_t'(oy);
        q.dest_x     = coord_t'(dx);
        q.dest_y     = coord_t'(dy);
        gap = steady ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(TDATA_W - IN_BITS){1'b0}}, q};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Result side: a random stall before each transfer, or a long one when
    // asked for, so that the pipeline fills and pushes back on the input.
    initial begin : result_sink
        int gap;
        m_tready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (hold_requests > 0) begin
                hold_requests--;
                gap = LONG_HOLD;
            end else begin
                gap = steady ? 0 : $urandom_range(0, 11);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    initial begin : run_limit
        #5000000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        int sx, sy, ox, oy, dx, dy;
        int span, base, t, stepx, stepy, len;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        steady   = 1'b0;
        hold_requests = 0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed queries: zero length, extremes, touching at a corner,
        // collinear with one diagonal, vertical and horizontal segments.
        offer_query(0, 0, 0, 0, 0, 0);
        offer_query(1023, 1023, 1023, 1023, 1023, 1023);
        offer_query(0, 0, 0, 0, 1023, 1023);
        offer_query(0, 0, 1023, 1023, 1023, 1023);
        offer_query(0, 0, 1, 0, 1, 1);
        offer_query(0, 0, 2, 0, 1, 1);
        offer_query(5, 0, 5, 5, 5, 10);
        offer_query(5, 0, 6, 5, 5, 10);
        offer_query(5, 0, 4, 5, 5, 10);
        offer_query(0, 7, 500, 7, 1023, 7);
        offer_query(1023, 0, 511, 511, 0, 1023);
        offer_query(1023, 0, 0, 1023, 0, 1023);
        offer_query(10, 10, 12, 12, 11, 10);
        offer_query(0, 0, 5, 5, 3, 3);
        offer_query(100, 200, 100, 200, 101, 200);
        offer_query(0, 0, 1, 3, 2, 7);
        offer_query(1023, 1023, 1022, 1022, 1021, 1021);
        offer_query(512, 0, 512, 1023, 512, 1023);
        offer_query(682, 341, 682, 341, 341, 682);
        offer_query(0, 1023, 1023, 0, 1023, 0);

        for (int n = 0; n < RANDOM_QUERIES; n++) begin
            steady = ((n / 150) % 3 == 2);
            if (n == 300 || n == 900) begin
                hold_requests++;
            end
            sx = $urandom_range(0, COORD_MAX);
            sy = $urandom_range(0, COORD_MAX);
            ox = $urandom_range(0, COORD_MAX);
            oy = $urandom_range(0, COORD_MAX);
            dx = $urandom_range(0, COORD_MAX);
            dy = $urandom_range(0, COORD_MAX);
            case ($urandom_range(0, 9))
                2, 3, 4: begin
                    // Obstacle placed on or next to the segment.
                    case ($urandom_range(0, 3))
                        0: span = 3;
                        1: span = 15;
                        2: span = 127;
                        default: span = COORD_MAX;
                    endcase
                    dx = clamp_coord(sx + $urandom_range(0, 2 * span) - span);
                    dy = clamp_coord(sy + $urandom_range(0, 2 * span) - span);
                    t  = $urandom_range(0, 256);
                    ox = clamp_coord(sx + ((dx - sx) * t) / 256 + $urandom_range(0, 2) - 1);
                    oy = clamp_coord(sy + ((dy - sy) * t) / 256 + $urandom_range(0, 2) - 1);
                end
                5, 6: begin
                    // All three cells in a small window.
                    base = $urandom_range(0, COORD_MAX);
                    sx = clamp_coord(base + $urandom_range(0, 7));
                    dx = clamp_coord(base + $urandom_range(0, 7));
                    ox = clamp_coord(base + $urandom_range(0, 7));
                    base = $urandom_range(0, COORD_MAX);
                    sy = clamp_coord(base + $urandom_range(0, 7));
                    dy = clamp_coord(base + $urandom_range(0, 7));
                    oy = clamp_coord(base + $urandom_range(0, 7));
                end
                7: begin
                    // Axis-aligned and 45 degree segments, parallel cases.
                    stepx = $urandom_range(0, 2) - 1;
                    stepy = $urandom_range(0, 2) - 1;
                    len   = $urandom_range(1, 20);
                    dx = clamp_coord(sx + stepx * len);
                    dy = clamp_coord(sy + stepy * len);
                    t  = $urandom_range(0, len);
                    ox = clamp_coord(sx + stepx * t + $urandom_range(0, 2) - 1);
                    oy = clamp_coord(sy + stepy * t + $urandom_range(0, 2) - 1);
                end
                8: begin
                    // Zero length, or the obstacle on an end cell.
                    case ($urandom_range(0, 2))
                        0: begin
                            dx = sx;
                            dy = sy;
                        end
                        1: begin
                            ox = sx;
                            oy = sy;
                        end
                        default: begin
                            ox = dx;
                            oy = dy;
                        end
                    endcase
                end
                9: begin
                    // Grid edges for source and obstacle, one cell in for the destination.
                    if ($urandom_range(0, 1)) sx = $urandom_range(0, 1) ? COORD_MAX : 0;
                    if ($urandom_range(0, 1)) sy = $urandom_range(0, 1) ? COORD_MAX : 0;
                    if ($urandom_range(0, 1)) ox = $urandom_range(0, 1) ? COORD_MAX : 0;
                    if ($urandom_range(0, 1)) oy = $urandom_range(0, 1) ? COORD_MAX : 0;
                    if ($urandom_range(0, 1)) dx = $urandom_range(0, 1) ? COORD_MAX - 1 : 1;
                    if ($urandom_range(0, 1)) dy = $urandom_range(0, 1) ? COORD_MAX - 1 : 1;
                end
                default: begin
                end
            endcase
            offer_query(sx, sy, ox, oy, dx, dy);
        end
        s_tvalid <= 1'b0;
        steady = 1'b0;

        while (outstanding != 0) @(negedge aclk);
        repeat (16) @(negedge aclk);

        $display("%0d occlusion verdicts compared, %0d of them blocked.",
                 verdicts_checked, blocked_seen);
        $display("Random gaps on both sides, gapless stretches and two long output stalls.");
        if (mismatches == 0 && outstanding == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
